FILE: rtl/core/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

  // operand width of modulus, base, exponent and result
  localparam int WORD_BITS = 63;
  // width of the step counter of the shift-and-add unit
  localparam int CNT_W = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // one input transaction
  typedef struct packed {
    word_t modulus;
    word_t base_value;
    word_t exponent;
  } in_t;

  // one result transaction
  typedef struct packed {
    word_t power_result;
    logic  bad_modulus;
  } out_t;

endpackage

FILE: rtl/core/modular_exponentiation.sv
// modular exponentiation by right-to-left square-and-multiply on a shared modmul unit
// zero modulus gives its strobe in the cycle after start is taken; otherwise the
//   result comes from the bit-serial modular multiply/reduce unit that retires one
//   bit per cycle
// throughput: one transaction at a time; busy is high until the result strobe cycle
// reset: rst_n synchronous active low clears the sequencer and the result strobe
`timescale 1ns / 1ps

module modular_exponentiation (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mexp_pkg::in_t  in_data,
  output logic           out_valid,
  output mexp_pkg::out_t out_data
);

  localparam int W = mexp_pkg::WORD_BITS;
  localparam int CW = mexp_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);
  localparam logic [W-1:0] ONE = W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  work_r, work_nxt;
  logic [W-1:0]  mbits_r, mbits_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          bad_r, bad_nxt;
  logic          out_valid_r, out_valid_nxt;

  // shared unit: work = (2*work + bit*a) mod m, all candidates in parallel
  logic [W+2:0] s_x, m_x, m2_x, a_x, d_s, p, p1, p2;
  logic [W-1:0] unit_res;
  logic         ge_s;

  always_comb begin
    s_x  = {2'b00, work_r, 1'b0};
    m_x  = {3'b000, m_r};
    m2_x = {2'b00, m_r, 1'b0};
    a_x  = mbits_r[W-1] ? {3'b000, a_r} : '0;
    d_s  = s_x - m_x;
    ge_s = !d_s[W+2];
    p    = s_x + a_x;
    p1   = p - m_x;
    p2   = p - m2_x;
    if (ge_s) begin
      unit_res = p2[W+2] ? p1[W-1:0] : p2[W-1:0];
    end else begin
      unit_res = p1[W+2] ? p[W-1:0] : p1[W-1:0];
    end
  end

  // sequencer
  always_comb begin
    logic [W-1:0] rem;
    state_nxt     = state_r;
    m_nxt         = m_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    work_nxt      = work_r;
    mbits_nxt     = mbits_r;
    a_nxt         = a_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    out_valid_nxt = 1'b0;
    rem           = e_r >> 1;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          m_nxt = in_data.modulus;
          b_nxt = in_data.base_value;
          e_nxt = in_data.exponent;
          if (in_data.modulus == '0) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
            bad_nxt       = 1'b1;
          end else begin
            state_nxt = ST_REDUCE;
            work_nxt  = '0;
            mbits_nxt = in_data.base_value;
            a_nxt     = ONE;
            cnt_nxt   = CNT_LAST;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        work_nxt  = unit_res;
        mbits_nxt = mbits_r << 1;
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          work_nxt = '0;
          cnt_nxt  = CNT_LAST;
          case (state_r)
            ST_REDUCE: begin
              b_nxt   = unit_res;
              acc_nxt = ONE;
              if (e_r == '0) begin
                state_nxt     = ST_IDLE;
                out_valid_nxt = 1'b1;
                res_nxt       = ONE;
                bad_nxt       = 1'b0;
              end else if (e_r[0]) begin
                state_nxt = ST_MUL;
                a_nxt     = ONE;
                mbits_nxt = unit_res;
              end else begin
                state_nxt = ST_SQR;
                a_nxt     = unit_res;
                mbits_nxt = unit_res;
              end
            end
            ST_MUL: begin
              acc_nxt = unit_res;
              // last set bit: the trailing square is not needed
              if (rem == '0) begin
                state_nxt     = ST_IDLE;
                out_valid_nxt = 1'b1;
                res_nxt       = unit_res;
                bad_nxt       = 1'b0;
              end else begin
                state_nxt = ST_SQR;
                a_nxt     = b_r;
                mbits_nxt = b_r;
              end
            end
            default: begin
              b_nxt = unit_res;
              e_nxt = rem;
              if (rem == '0) begin
                state_nxt     = ST_IDLE;
                out_valid_nxt = 1'b1;
                res_nxt       = acc_r;
                bad_nxt       = 1'b0;
              end else if (rem[0]) begin
                state_nxt = ST_MUL;
                a_nxt     = acc_r;
                mbits_nxt = unit_res;
              end else begin
                state_nxt = ST_SQR;
                a_nxt     = unit_res;
                mbits_nxt = unit_res;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r     <= m_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    acc_r   <= acc_nxt;
    work_r  <= work_nxt;
    mbits_r <= mbits_nxt;
    a_r     <= a_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    bad_r   <= bad_nxt;
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_data.power_result = res_r;
  assign out_data.bad_modulus  = bad_r;

  // strobe only comes with the sequencer back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // zero modulus answers in the next cycle with the error flag
  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.modulus == '0) |=>
      (out_valid && out_data.bad_modulus && out_data.power_result == '0))
    else $error("zero modulus not flagged");

  // partial sum of the shared unit stays reduced
  a_work_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (work_r < m_r))
    else $error("unit accumulator not below modulus");

  // the running power is reduced once past the base reduction
  a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_SQR) |-> (b_r < m_r))
    else $error("base power not below modulus");

endmodule
